### hdl/aehp_pkg.sv
`default_nettype none

package aehp_pkg;

   // Number of header bytes kept per frame, and the widest header the parser can address.
   localparam int HEADER_BYTES_DEFAULT = 12;
   localparam int MAX_HEADER_BITS      = 128;

   // Depth of the header queue between the byte collector and the parser.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] SYNC_WORD = 16'h0B77;

   // Width of the result stream data bus.
   localparam int RSP_TDATA_W = 72;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SYNC_ERR = 2'd1,
      STATUS_RATE_ERR = 2'd2
   } status_type;

   // One parsed header. The first member sits in the highest bits, so status lands in bits [1:0].
   typedef struct packed {
      logic [3:0]  channel_total;
      logic        lfe_present;
      logic [3:0]  extension_channels;
      logic [2:0]  base_channels;
      logic [19:0] duration_ticks;
      logic [2:0]  audio_blocks;
      logic [12:0] payload_bytes;
      logic [15:0] sample_rate;
      logic [2:0]  substream_id;
      logic [1:0]  stream_type;
      status_type  status;
   } result_type;

endpackage

`default_nettype wire

### hdl/aehp_front.sv
`default_nettype none

module aehp_front
   import aehp_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tuser,
   input  logic                    enhanced,
   input  logic                    q_full,
   output logic                    push_valid,
   output logic [HEADER_BYTES*8:0] push_data
);

   localparam int CW = $clog2(HEADER_BYTES + 1);
   localparam int IW = $clog2(HEADER_BYTES);
   localparam logic [CW-1:0] LAST_IDX = CW'(HEADER_BYTES - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(HEADER_BYTES);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_eff;
   logic [7:0]    store_ff [HEADER_BYTES];
   logic          accept;
   logic          store_en;

   // The collector only waits when the queue cannot take another header.
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      count_eff  = req_tuser ? '0 : count_ff;
      store_en   = accept && (count_eff < FULL_CNT);
      count_in   = count_ff;
      if (accept) begin
         count_in = store_en ? count_eff + 1'b1 : count_eff;
      end
      push_valid = store_en && (count_eff == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         store_ff[count_eff[IW-1:0]] <= req_tdata;
      end
   end

   // Byte 0 goes to the top of the header word; the last byte comes straight from the bus.
   always_comb begin
      push_data[HEADER_BYTES*8] = enhanced;
      for (int i = 0; i < HEADER_BYTES; i++) begin
         push_data[(HEADER_BYTES-i)*8-1 -: 8] = (i == HEADER_BYTES - 1) ? req_tdata : store_ff[i];
      end
   end

endmodule

`default_nettype wire

### hdl/aehp_queue.sv
`default_nettype none

module aehp_queue
   import aehp_pkg::*;
#(
   parameter int WIDTH = HEADER_BYTES_DEFAULT * 8 + 1,
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push_valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/aehp_back.sv
`default_nettype none

module aehp_back
   import aehp_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic [HEADER_BYTES*8:0] pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output result_type              rsp_result
);

   localparam int HW  = HEADER_BYTES * 8;
   localparam int PW  = MAX_HEADER_BITS;
   localparam int TOP = PW - 1;
   localparam logic [6:0] TOP_IDX = 7'(TOP);
   localparam logic [1:0] STRM_INDEP = 2'd0;
   localparam logic [1:0] STRM_DEP   = 2'd1;
   localparam longint TICK_SCALE = 64'd2560000000;

   typedef enum logic [2:0] {
      RATE_48K, RATE_44K1, RATE_32K, RATE_24K, RATE_22K05, RATE_16K, RATE_NONE
   } rate_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  strm;
      logic [2:0]  sub;
      rate_type    rate;
      logic [2:0]  blocks;
      logic [12:0] bytes;
      logic [2:0]  acmod;
      logic        lfe;
      logic        base_en;
      logic        ext_acmod_en;
      logic        map_en;
      logic [15:0] map;
   } stage_type;

   function automatic rate_type full_rate(input logic [1:0] code);
      case (code)
         2'd0:    return RATE_48K;
         2'd1:    return RATE_44K1;
         2'd2:    return RATE_32K;
         default: return RATE_NONE;
      endcase
   endfunction

   function automatic rate_type half_rate(input logic [1:0] code);
      case (code)
         2'd0:    return RATE_24K;
         2'd1:    return RATE_22K05;
         2'd2:    return RATE_16K;
         default: return RATE_NONE;
      endcase
   endfunction

   function automatic logic [15:0] rate_hz(input rate_type rate);
      case (rate)
         RATE_48K:   return 16'd48000;
         RATE_44K1:  return 16'd44100;
         RATE_32K:   return 16'd32000;
         RATE_24K:   return 16'd24000;
         RATE_22K05: return 16'd22050;
         RATE_16K:   return 16'd16000;
         default:    return 16'd0;
      endcase
   endfunction

   // Frame duration in 100 ns units for every rate and block count that can occur.
   function automatic logic [19:0] ticks(input rate_type rate, input logic [2:0] blocks);
      logic [19:0] t;
      t = '0;
      case (rate)
         RATE_48K: begin
            case (blocks)
               3'd1:    t = 20'(TICK_SCALE / 48000);
               3'd2:    t = 20'(2 * TICK_SCALE / 48000);
               3'd3:    t = 20'(3 * TICK_SCALE / 48000);
               3'd6:    t = 20'(6 * TICK_SCALE / 48000);
               default: t = '0;
            endcase
         end
         RATE_44K1: begin
            case (blocks)
               3'd1:    t = 20'(TICK_SCALE / 44100);
               3'd2:    t = 20'(2 * TICK_SCALE / 44100);
               3'd3:    t = 20'(3 * TICK_SCALE / 44100);
               3'd6:    t = 20'(6 * TICK_SCALE / 44100);
               default: t = '0;
            endcase
         end
         RATE_32K: begin
            case (blocks)
               3'd1:    t = 20'(TICK_SCALE / 32000);
               3'd2:    t = 20'(2 * TICK_SCALE / 32000);
               3'd3:    t = 20'(3 * TICK_SCALE / 32000);
               3'd6:    t = 20'(6 * TICK_SCALE / 32000);
               default: t = '0;
            endcase
         end
         RATE_24K:   t = (blocks == 3'd6) ? 20'(6 * TICK_SCALE / 24000) : '0;
         RATE_22K05: t = (blocks == 3'd6) ? 20'(6 * TICK_SCALE / 22050) : '0;
         RATE_16K:   t = (blocks == 3'd6) ? 20'(6 * TICK_SCALE / 16000) : '0;
         default:    t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [9:0] ac3_kbps(input logic [4:0] idx);
      case (idx)
         5'd0:    return 10'd32;
         5'd1:    return 10'd40;
         5'd2:    return 10'd48;
         5'd3:    return 10'd56;
         5'd4:    return 10'd64;
         5'd5:    return 10'd80;
         5'd6:    return 10'd96;
         5'd7:    return 10'd112;
         5'd8:    return 10'd128;
         5'd9:    return 10'd160;
         5'd10:   return 10'd192;
         5'd11:   return 10'd224;
         5'd12:   return 10'd256;
         5'd13:   return 10'd320;
         5'd14:   return 10'd384;
         5'd15:   return 10'd448;
         5'd16:   return 10'd512;
         5'd17:   return 10'd576;
         5'd18:   return 10'd640;
         default: return 10'd0;
      endcase
   endfunction

   // Words per frame at 44.1 kHz for the even size codes (320 * kbps / 147, truncated).
   function automatic logic [10:0] ac3_words44(input logic [4:0] idx);
      case (idx)
         5'd0:    return 11'd69;
         5'd1:    return 11'd87;
         5'd2:    return 11'd104;
         5'd3:    return 11'd121;
         5'd4:    return 11'd139;
         5'd5:    return 11'd174;
         5'd6:    return 11'd208;
         5'd7:    return 11'd243;
         5'd8:    return 11'd278;
         5'd9:    return 11'd348;
         5'd10:   return 11'd417;
         5'd11:   return 11'd487;
         5'd12:   return 11'd557;
         5'd13:   return 11'd696;
         5'd14:   return 11'd835;
         5'd15:   return 11'd975;
         5'd16:   return 11'd1114;
         5'd17:   return 11'd1253;
         5'd18:   return 11'd1393;
         default: return 11'd0;
      endcase
   endfunction

   function automatic logic [12:0] ac3_bytes(input logic [1:0] fscod, input logic [5:0] code);
      logic [9:0]  kbps;
      logic [10:0] w44;
      logic [12:0] r;
      kbps = ac3_kbps(code[5:1]);
      w44  = ac3_words44(code[5:1]);
      r    = '0;
      if (code < 6'd38) begin
         case (fscod)
            2'd0:    r = 13'(kbps) << 2;
            2'd1:    r = {1'b0, w44 + 11'(code[0]), 1'b0};
            2'd2:    r = 13'(kbps) * 13'd6;
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [2:0] acmod_channels(input logic [2:0] acmod);
      case (acmod)
         3'd0:    return 3'd2;
         3'd1:    return 3'd1;
         3'd2:    return 3'd2;
         3'd3:    return 3'd3;
         3'd4:    return 3'd3;
         3'd5:    return 3'd4;
         3'd6:    return 3'd4;
         default: return 3'd5;
      endcase
   endfunction

   logic [PW-1:0] bits;
   logic          enh;
   logic [15:0]   sync;
   logic [1:0]    a_fscod;
   logic [5:0]    a_code;
   logic [2:0]    a_acmod;
   logic [6:0]    a_lfe_pos;
   logic          a_lfe;
   logic [1:0]    e_strm;
   logic [2:0]    e_sub;
   logic [10:0]   e_frmsiz;
   logic [1:0]    e_fscod;
   logic [1:0]    e_fscod2;
   logic [2:0]    e_acmod;
   logic          e_lfe;
   logic          e_compre;
   logic [6:0]    e_mix_pos;
   logic          e_compr2e;
   logic [6:0]    e_map_pos;
   logic          e_chanmape;
   logic [15:0]   e_map;

   stage_type  s1_in;
   stage_type  s1_ff;
   logic       s1_v_ff;
   logic       s1_ready;
   logic       s2_ready;
   logic       rsp_v_ff;
   result_type res_in;
   result_type res_ff;
   logic [2:0] ach;
   logic [2:0] base;
   logic [3:0] ext;
   logic       lfe;

   // Bit p of the stream sits at bits[TOP - p]; positions past the header read zero.
   assign bits = PW'(pop_data[HW-1:0]) << (PW - HW);
   assign enh  = pop_data[HW];

   always_comb begin
      sync      = bits[TOP -: 16];
      a_fscod   = bits[TOP-32 -: 2];
      a_code    = bits[TOP-34 -: 6];
      a_acmod   = bits[TOP-48 -: 3];
      a_lfe_pos = 7'd51
                + ((a_acmod[0] && a_acmod != 3'd1) ? 7'd2 : 7'd0)
                + (a_acmod[2] ? 7'd2 : 7'd0)
                + ((a_acmod == 3'd2) ? 7'd2 : 7'd0);
      a_lfe     = bits[TOP_IDX - a_lfe_pos];

      e_strm     = bits[TOP-16 -: 2];
      e_sub      = bits[TOP-18 -: 3];
      e_frmsiz   = bits[TOP-21 -: 11];
      e_fscod    = bits[TOP-32 -: 2];
      e_fscod2   = bits[TOP-34 -: 2];
      e_acmod    = bits[TOP-36 -: 3];
      e_lfe      = bits[TOP-39];
      e_compre   = bits[TOP-50];
      e_mix_pos  = 7'd51 + (e_compre ? 7'd8 : 7'd0);
      e_compr2e  = bits[TOP_IDX - (e_mix_pos + 7'd5)];
      e_map_pos  = e_mix_pos + ((e_acmod == 3'd0) ? (e_compr2e ? 7'd14 : 7'd6) : 7'd0);
      e_chanmape = bits[TOP_IDX - e_map_pos];
      e_map      = bits[TOP_IDX - e_map_pos - 7'd1 -: 16];

      s1_in      = '0;
      s1_in.rate = RATE_NONE;
      if (sync != SYNC_WORD) begin
         s1_in.status = STATUS_SYNC_ERR;
      end else if (!enh) begin
         if (a_fscod == 2'd3) begin
            s1_in.status = STATUS_RATE_ERR;
         end else begin
            s1_in.status  = STATUS_OK;
            s1_in.rate    = full_rate(a_fscod);
            s1_in.blocks  = 3'd6;
            s1_in.bytes   = ac3_bytes(a_fscod, a_code);
            s1_in.acmod   = a_acmod;
            s1_in.lfe     = a_lfe;
            s1_in.base_en = 1'b1;
         end
      end else if (e_fscod == 2'd3 && e_fscod2 == 2'd3) begin
         s1_in.status = STATUS_RATE_ERR;
      end else begin
         s1_in.status = STATUS_OK;
         s1_in.strm   = e_strm;
         s1_in.sub    = e_sub;
         if (e_fscod == 2'd3) begin
            s1_in.rate   = half_rate(e_fscod2);
            s1_in.blocks = 3'd6;
         end else begin
            s1_in.rate   = full_rate(e_fscod);
            s1_in.blocks = (e_fscod2 == 2'd3) ? 3'd6 : {1'b0, e_fscod2} + 3'd1;
         end
         s1_in.bytes = {{1'b0, e_frmsiz} + 12'd1, 1'b0};
         s1_in.acmod = e_acmod;
         s1_in.lfe   = e_lfe;
         case (e_strm)
            STRM_INDEP: s1_in.base_en = 1'b1;
            STRM_DEP: begin
               if (e_chanmape) begin
                  s1_in.map_en = 1'b1;
                  s1_in.map    = e_map;
               end else begin
                  s1_in.ext_acmod_en = 1'b1;
               end
            end
            default: s1_in.base_en = 1'b0;
         endcase
      end
   end

   always_comb begin
      ach  = acmod_channels(s1_ff.acmod);
      base = s1_ff.base_en ? ach : 3'd0;
      if (s1_ff.map_en) begin
         ext = 4'($countones(s1_ff.map[15:5]));
      end else if (s1_ff.ext_acmod_en) begin
         ext = {1'b0, ach};
      end else begin
         ext = 4'd0;
      end
      lfe = s1_ff.lfe || (s1_ff.map_en && s1_ff.map[4]);

      res_in                    = '0;
      res_in.status             = s1_ff.status;
      res_in.stream_type        = s1_ff.strm;
      res_in.substream_id       = s1_ff.sub;
      res_in.sample_rate        = rate_hz(s1_ff.rate);
      res_in.payload_bytes      = s1_ff.bytes;
      res_in.audio_blocks       = s1_ff.blocks;
      res_in.duration_ticks     = ticks(s1_ff.rate, s1_ff.blocks);
      res_in.base_channels      = base;
      res_in.extension_channels = ext;
      res_in.lfe_present        = lfe;
      res_in.channel_total      = {1'b0, base} + ext + 4'(lfe);
   end

   assign s2_ready   = !rsp_v_ff || rsp_ready;
   assign s1_ready   = !s1_v_ff || s2_ready;
   assign pop_ready  = s1_ready;
   assign rsp_valid  = rsp_v_ff;
   assign rsp_result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= pop_valid;
         end
         if (s2_ready) begin
            rsp_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && pop_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_ready && s1_v_ff) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ac3_eac3_header_parser_core.sv
// From the queue a header goes through the s1 register and the output register to the result.
// Throughput: one header byte per cycle; a result at most once per HEADER_BYTES bytes.
// The byte collector stalls only while the two-entry header queue is full.
// Reset (synchronous, active high) clears the byte count, the queue, the pipeline valids and
// selects AC-3 parsing. The header bytes themselves are not cleared.
`default_nettype none

module ac3_eac3_header_parser_core
   import aehp_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Configuration: codec select, 0 for AC-3, 1 for E-AC-3.
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tuser,   // [0] frame_start
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] status, [3:2] stream_type, [6:4] substream_id, [22:7] sample_rate,
   // [35:23] payload_bytes, [38:36] audio_blocks, [58:39] duration_ticks,
   // [61:59] base_channels, [65:62] extension_channels, [66] lfe_present,
   // [70:67] channel_total, [71] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int QW = HEADER_BYTES * 8 + 1;

   logic          enhanced_ff;
   logic          q_full;
   logic          push_valid;
   logic [QW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [QW-1:0] pop_data;
   result_type    result;

   // The user must change the codec select only while the block is idle; the block does not
   // enforce this. Each header takes the value that is current when its last byte arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         enhanced_ff <= 1'b0;
      end else if (csr_wr_en) begin
         enhanced_ff <= csr_wr_data;
      end
   end

   // The front end counts the bytes of each request run. A request that carries the
   // frame start flag restarts the count, and bytes after a full header are dropped
   // until the next frame start. The last header byte pushes the whole header, tagged
   // with the codec select, into the queue.
   aehp_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .enhanced   (enhanced_ff),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // The queue lets the collector keep taking bytes of the next frame while a parsed
   // result is still waiting on the result channel.
   aehp_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The back end parses in two stages: field extraction and table lookups, then the
   // channel counts and duration, which are held in the output register.
   aehp_back #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = RSP_TDATA_W'(result);

endmodule

`default_nettype wire

### hdl/aehp_checker.sv
`default_nettype none

module aehp_checker
   import aehp_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   result_type r;

   assign r = result_type'(rsp_tdata[$bits(result_type)-1:0]);

   // No result survives a reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // An error result carries nothing but its status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (r.status == STATUS_SYNC_ERR || r.status == STATUS_RATE_ERR)
      |-> rsp_tdata[RSP_TDATA_W-1:2] == '0)
      else $error("error result carries field data");

   // A good result has blocks, a sample rate and a channel total that adds up.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.status == STATUS_OK
      |-> r.audio_blocks != 3'd0 && r.sample_rate != 16'd0
          && r.channel_total == 4'(r.base_channels) + r.extension_channels
                                + 4'(r.lfe_present))
      else $error("inconsistent good result");

endmodule

bind ac3_eac3_header_parser_core aehp_checker u_aehp_checker (.*);

`default_nettype wire
